@@ sv/psdt_pkg.sv @@
// Shared types, constants and codes for the point splat depth test block.
package psdt_pkg;

	// Default viewport and depth precision
	localparam int DEF_VIEW_WIDTH  = 1280;
	localparam int DEF_VIEW_HEIGHT = 720;
	localparam int DEF_DEPTH_BITS  = 24;

	// Clip-space coordinate width: three floored Q16.16 products plus one term
	localparam int CW = 50;

	// Register file
	localparam int NUM_REGS = 8;
	localparam int REG_W    = 64;
	localparam int ADDR_W   = 6;

	typedef logic [NUM_REGS-1:0][REG_W-1:0] mvp_t;

	// Identity matrix in Q16.16
	localparam mvp_t MVP_RESET = {
		64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
		64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
	};

	// Request and result codes
	localparam logic REQ_DRAW  = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	localparam logic [1:0] OUT_WRITTEN  = 2'd0;
	localparam logic [1:0] OUT_CLIPPED  = 2'd1;
	localparam logic [1:0] OUT_OCCLUDED = 2'd2;
	localparam logic [1:0] OUT_CLEARED  = 2'd3;

	localparam logic [7:0] ALPHA = 8'hFF;

	typedef struct packed {
		logic               req_type;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [15:0]        hue;
		logic [15:0]        saturation;
		logic [15:0]        brightness;
	} in_t;

	typedef struct packed {
		logic        write_pixel;
		logic [19:0] pixel_index;
		logic [31:0] pixel_color;
		logic [1:0]  outcome;
	} out_t;

endpackage

@@ sv/point_splat_depth_test.sv @@
// Point splat depth test: transform, clip, project, color and z-test one point per request.
// One request is processed at a time. A draw runs the matrix multiply on a single shared
// 32x32 multiplier, a clip check, then three divisions on one shared bit-serial divider
// (column, row, depth), then the index, depth store read, compare and result states. Once
// the result word is loaded, the block returns to idle and takes the next request. A
// clipped point skips the divisions. A clear request returns its result word first and
// then sweeps the depth store, one entry per cycle, over all VIEW_WIDTH*VIEW_HEIGHT
// entries (921600 by default); the same sweep runs after reset. No request is taken
// during a sweep; register writes are. The result is held in an output register, so a
// request may start while the previous result waits to be taken.
module point_splat_depth_test
	import psdt_pkg::*;
#(
	parameter int VIEW_WIDTH  = DEF_VIEW_WIDTH,
	parameter int VIEW_HEIGHT = DEF_VIEW_HEIGHT,
	parameter int DEPTH_BITS  = DEF_DEPTH_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [REG_W-1:0]  pwdata,
	output logic [REG_W-1:0]  prdata,
	output logic              pready,
	input  in_t               item,
	input  logic              item_valid,
	output logic              item_ready,
	output out_t              result,
	output logic              result_valid,
	input  logic              result_ready
);

	localparam int STORE = VIEW_WIDTH * VIEW_HEIGHT;
	localparam int IDX_W = $clog2(STORE);
	localparam int COL_W = $clog2(VIEW_WIDTH);
	localparam int ROW_W = $clog2(VIEW_HEIGHT);
	localparam int HW    = VIEW_WIDTH / 2;
	localparam int HH    = VIEW_HEIGHT / 2;
	localparam int SW    = CW + 1;
	localparam int QW    = DEPTH_BITS > 12 ? DEPTH_BITS : 12;
	localparam int RW    = SW + QW + 1;
	localparam int NBW   = $clog2(QW + 1);

	localparam logic [3:0] S_SWEEP = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_MUL   = 4'd2;
	localparam logic [3:0] S_CLIP  = 4'd3;
	localparam logic [3:0] S_DCOL  = 4'd4;
	localparam logic [3:0] S_DROW  = 4'd5;
	localparam logic [3:0] S_DZ    = 4'd6;
	localparam logic [3:0] S_IDX   = 4'd7;
	localparam logic [3:0] S_RD    = 4'd8;
	localparam logic [3:0] S_CMP   = 4'd9;
	localparam logic [3:0] S_FIN   = 4'd10;

	logic [3:0]            state_q;
	mvp_t                  mvp_q;
	in_t                   item_q;
	logic [IDX_W-1:0]      sweep_q;
	logic [COL_W-1:0]      col_q;
	logic [ROW_W-1:0]      row_q;
	logic [DEPTH_BITS-1:0] dq_q;
	logic [IDX_W-1:0]      idx_q;
	logic [1:0]            fin_q;
	out_t                  out_q;
	logic                  out_valid_q;

	logic                  xf_start;
	logic                  xf_done;
	logic signed [CW-1:0]  cx, cy, cz, cw;
	logic signed [SW-1:0]  sx, sy, sz, sw;
	logic [SW-1:0]         x_pw, w_my, z_pw, w2;
	logic                  in_cube;

	logic                  div_start;
	logic [RW-1:0]         div_num;
	logic [SW-1:0]         div_den;
	logic [NBW-1:0]        div_nbits;
	logic                  div_done;
	logic [QW-1:0]         div_quo;

	logic [31:0]           argb;
	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	logic [DEPTH_BITS-1:0] mem_wdata;
	logic [DEPTH_BITS-1:0] mem_rdata;
	logic                  occluded;
	logic                  out_free;
	logic                  cfg_we;

	// Register file
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign prdata = mvp_q[paddr[ADDR_W-1:3]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvp_q <= MVP_RESET;
		end else if (cfg_we) begin
			mvp_q[paddr[ADDR_W-1:3]] <= pwdata;
		end
	end

	// Matrix transform
	psdt_xform u_xform (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (xf_start),
		.mvp    (mvp_q),
		.pos_x  (item_q.pos_x),
		.pos_y  (item_q.pos_y),
		.pos_z  (item_q.pos_z),
		.done   (xf_done),
		.clip_x (cx),
		.clip_y (cy),
		.clip_z (cz),
		.clip_w (cw)
	);

	// Strict clip cube and nonnegative numerators for the divisions
	always_comb begin
		sx      = SW'(cx);
		sy      = SW'(cy);
		sz      = SW'(cz);
		sw      = SW'(cw);
		in_cube = (-cw < cx) && (cx < cw) && (-cw < cy) && (cy < cw) &&
			(-cw < cz) && (cz < cw);
		x_pw    = SW'(sx + sw);
		w_my    = SW'(sw - sy);
		z_pw    = SW'(sz + sw);
		w2      = SW'(sw <<< 1);
	end

	// Divider operand select: column, row, then depth
	always_comb begin
		div_start = 1'b0;
		div_num   = RW'(x_pw) * RW'(HW);
		div_den   = SW'(cw);
		div_nbits = NBW'(COL_W);
		unique case (state_q)
			S_CLIP: div_start = in_cube;
			S_DCOL: begin
				div_start = div_done;
				div_num   = RW'(w_my) * RW'(HH);
				div_nbits = NBW'(ROW_W);
			end
			S_DROW: begin
				div_start = div_done;
				div_num   = RW'(z_pw) << DEPTH_BITS;
				div_den   = w2;
				div_nbits = NBW'(DEPTH_BITS);
			end
			default: ;
		endcase
	end

	psdt_div #(.RW(RW), .DW(SW), .QW(QW), .NBW(NBW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.nbits  (div_nbits),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Color path runs from the held request word
	psdt_hsv u_hsv (
		.clk        (clk),
		.hue        (item_q.hue),
		.saturation (item_q.saturation),
		.brightness (item_q.brightness),
		.argb       (argb)
	);

	// Depth store: sweep writes zero, compare writes the nearer depth
	assign occluded  = (mem_rdata != '0) && (dq_q >= mem_rdata);
	assign mem_we    = (state_q == S_SWEEP) || (state_q == S_CMP && !occluded);
	assign mem_waddr = (state_q == S_SWEEP) ? sweep_q : idx_q;
	assign mem_wdata = (state_q == S_SWEEP) ? '0 : dq_q;

	psdt_zbuf #(.DEPTH(STORE), .AW(IDX_W), .DW(DEPTH_BITS)) u_zbuf (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (idx_q),
		.rdata (mem_rdata)
	);

	assign item_ready = state_q == S_IDLE;
	assign xf_start   = item_valid && item_ready && item.req_type == REQ_DRAW;
	assign out_free   = !out_valid_q || result_ready;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == IDX_W'(STORE - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_valid) begin
						state_q <= (item.req_type == REQ_CLEAR) ? S_FIN : S_MUL;
					end
				end
				S_MUL: begin
					if (xf_done) begin
						state_q <= S_CLIP;
					end
				end
				S_CLIP: state_q <= in_cube ? S_DCOL : S_FIN;
				S_DCOL: begin
					if (div_done) begin
						state_q <= S_DROW;
					end
				end
				S_DROW: begin
					if (div_done) begin
						state_q <= S_DZ;
					end
				end
				S_DZ: begin
					if (div_done) begin
						state_q <= S_IDX;
					end
				end
				S_IDX: state_q <= S_RD;
				S_RD:  state_q <= S_CMP;
				S_CMP: state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						sweep_q <= '0;
						state_q <= (fin_q == OUT_CLEARED) ? S_SWEEP : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q <= item;
			fin_q  <= OUT_CLEARED;
		end
		if (state_q == S_CLIP) begin
			fin_q <= OUT_CLIPPED;
		end
		if (state_q == S_DCOL && div_done) begin
			col_q <= COL_W'(div_quo);
		end
		if (state_q == S_DROW && div_done) begin
			row_q <= ROW_W'(div_quo);
		end
		if (state_q == S_DZ && div_done) begin
			dq_q <= (div_quo == '0) ? DEPTH_BITS'(1) : DEPTH_BITS'(div_quo);
		end
		if (state_q == S_IDX) begin
			idx_q <= IDX_W'(row_q) * IDX_W'(VIEW_WIDTH) + IDX_W'(col_q);
		end
		if (state_q == S_CMP) begin
			fin_q <= occluded ? OUT_OCCLUDED : OUT_WRITTEN;
		end
		if (state_q == S_FIN && out_free) begin
			out_q.outcome     <= fin_q;
			out_q.write_pixel <= fin_q == OUT_WRITTEN;
			out_q.pixel_index <= (fin_q == OUT_WRITTEN) ? 20'(idx_q) : '0;
			out_q.pixel_color <= (fin_q == OUT_WRITTEN) ? argb : '0;
		end
	end

	assign result       = out_q;
	assign result_valid = out_valid_q;

endmodule

@@ sv/psdt_xform.sv @@
// Matrix transform: one shared 32x32 multiplier, products accumulated per row.
module psdt_xform
	import psdt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  mvp_t                 mvp,
	input  logic signed [31:0]   pos_x,
	input  logic signed [31:0]   pos_y,
	input  logic signed [31:0]   pos_z,
	output logic                 done,
	output logic signed [CW-1:0] clip_x,
	output logic signed [CW-1:0] clip_y,
	output logic signed [CW-1:0] clip_z,
	output logic signed [CW-1:0] clip_w
);

	logic               issue_q;
	logic [1:0]         row_q;
	logic [1:0]         col_q;
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic [63:0]        word;
	logic signed [63:0] prod_s1;
	logic [1:0]         prow_s1;
	logic               pv_s1;
	logic               plast_s1;
	logic signed [CW-1:0] acc_q [4];

	// Operand select: element MVP[row][col] and point coordinate col
	always_comb begin
		word  = mvp[{row_q, col_q[1]}];
		mul_a = col_q[0] ? word[63:32] : word[31:0];
		case (col_q)
			2'd0:    mul_b = pos_x;
			2'd1:    mul_b = pos_y;
			default: mul_b = pos_z;
		endcase
	end

	// Issue sequencer over rows 0..3, columns 0..2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q  <= 1'b0;
			row_q    <= '0;
			col_q    <= '0;
			pv_s1    <= 1'b0;
			plast_s1 <= 1'b0;
		end else begin
			pv_s1    <= issue_q;
			plast_s1 <= issue_q && row_q == 2'd3 && col_q == 2'd2;
			if (start) begin
				issue_q <= 1'b1;
				row_q   <= '0;
				col_q   <= '0;
			end else if (issue_q) begin
				if (col_q == 2'd2) begin
					col_q <= '0;
					row_q <= row_q + 2'd1;
					if (row_q == 2'd3) begin
						issue_q <= 1'b0;
					end
				end else begin
					col_q <= col_q + 2'd1;
				end
			end
		end
	end

	// Product register
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		prow_s1 <= row_q;
	end

	// Accumulate floored products; column 3 times w=1.0 seeds each row
	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < 4; i++) begin
				acc_q[i] <= CW'($signed(mvp[2*i+1][63:32]));
			end
		end else if (pv_s1) begin
			acc_q[prow_s1] <= acc_q[prow_s1] + CW'(prod_s1 >>> 16);
		end
	end

	assign done   = plast_s1;
	assign clip_x = acc_q[0];
	assign clip_y = acc_q[1];
	assign clip_z = acc_q[2];
	assign clip_w = acc_q[3];

endmodule

@@ sv/psdt_div.sv @@
// Restoring divider for nonnegative operands, one quotient bit per cycle.
module psdt_div
	import psdt_pkg::*;
#(
	parameter int RW  = 84,
	parameter int DW  = 51,
	parameter int QW  = 24,
	parameter int NBW = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [RW-1:0]  num,
	input  logic [DW-1:0]  den,
	input  logic [NBW-1:0] nbits,
	output logic           done,
	output logic [QW-1:0]  quo
);

	logic [RW-1:0]  rem_q;
	logic [RW-1:0]  dsh_q;
	logic [NBW-1:0] cnt_q;
	logic [QW-1:0]  quo_q;
	logic           done_q;
	logic           ge;

	assign ge = rem_q >= dsh_q;

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= nbits;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NBW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: divisor starts aligned to the top quotient bit
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= RW'(den) << (nbits - 1'b1);
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[QW-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

@@ sv/psdt_hsv.sv @@
// HSV to ARGB color conversion, three register stages.
module psdt_hsv
	import psdt_pkg::*;
(
	input  logic        clk,
	input  logic [15:0] hue,
	input  logic [15:0] saturation,
	input  logic [15:0] brightness,
	output logic [31:0] argb
);

	localparam logic [16:0] ONE = 17'h1_0000;

	logic [18:0] h6;
	logic [16:0] one_m_f;
	logic [16:0] one_m_s;
	logic [31:0] sf_full;
	logic [32:0] sfi_full;
	logic [32:0] p_full;

	logic [2:0]  sec_s1;
	logic [15:0] sf_s1;
	logic [15:0] sfi_s1;
	logic [15:0] p_s1;
	logic [15:0] v_s1;
	logic        grey_s1;

	logic [32:0] q_full;
	logic [32:0] t_full;
	logic [2:0]  sec_s2;
	logic [15:0] q_s2;
	logic [15:0] t_s2;
	logic [15:0] p_s2;
	logic [15:0] v_s2;
	logic        grey_s2;

	logic [15:0] r_c;
	logic [15:0] g_c;
	logic [15:0] b_c;
	logic [31:0] argb_s3;

	function automatic logic [7:0] chan8(input logic [15:0] c);
		logic [23:0] prod;
		prod = 24'(c) * 24'd255;
		return prod[23:16];
	endfunction

	// Stage 1: sector, fraction and first-level products
	always_comb begin
		h6       = 19'(hue) * 19'd6;
		one_m_f  = ONE - {1'b0, h6[15:0]};
		one_m_s  = ONE - {1'b0, saturation};
		sf_full  = 32'(saturation) * 32'(h6[15:0]);
		sfi_full = 33'(saturation) * 33'(one_m_f);
		p_full   = 33'(brightness) * 33'(one_m_s);
	end

	always_ff @(posedge clk) begin
		sec_s1  <= h6[18:16];
		sf_s1   <= sf_full[31:16];
		sfi_s1  <= sfi_full[31:16];
		p_s1    <= p_full[31:16];
		v_s1    <= brightness;
		grey_s1 <= saturation == '0;
	end

	// Stage 2: q and t
	always_comb begin
		q_full = 33'(v_s1) * 33'(ONE - {1'b0, sf_s1});
		t_full = 33'(v_s1) * 33'(ONE - {1'b0, sfi_s1});
	end

	always_ff @(posedge clk) begin
		sec_s2  <= sec_s1;
		q_s2    <= q_full[31:16];
		t_s2    <= t_full[31:16];
		p_s2    <= p_s1;
		v_s2    <= v_s1;
		grey_s2 <= grey_s1;
	end

	// Stage 3: sector select and byte scaling
	always_comb begin
		if (grey_s2) begin
			r_c = v_s2; g_c = v_s2; b_c = v_s2;
		end else begin
			case (sec_s2)
				3'd0:    begin r_c = v_s2; g_c = t_s2; b_c = p_s2; end
				3'd1:    begin r_c = q_s2; g_c = v_s2; b_c = p_s2; end
				3'd2:    begin r_c = p_s2; g_c = v_s2; b_c = t_s2; end
				3'd3:    begin r_c = p_s2; g_c = q_s2; b_c = v_s2; end
				3'd4:    begin r_c = t_s2; g_c = p_s2; b_c = v_s2; end
				default: begin r_c = v_s2; g_c = p_s2; b_c = q_s2; end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		argb_s3 <= {ALPHA, chan8(r_c), chan8(g_c), chan8(b_c)};
	end

	assign argb = argb_s3;

endmodule

@@ sv/psdt_zbuf.sv @@
// Depth store: single-port write, registered read.
module psdt_zbuf
	import psdt_pkg::*;
#(
	parameter int DEPTH = 921600,
	parameter int AW    = 20,
	parameter int DW    = 24
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/psdt_chk.sv @@
// Port-level checker for the point splat depth test block, bound to the top level.
module psdt_chk
	import psdt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input in_t  item,
	input logic item_valid,
	input logic item_ready,
	input out_t result,
	input logic result_valid,
	input logic result_ready
);

	// A stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// Only a written pixel carries index and color
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.outcome != OUT_WRITTEN |->
		!result.write_pixel && result.pixel_index == '0 && result.pixel_color == '0)
		else $error("non-write result carries payload");

	// A written pixel is flagged and opaque
	a_write: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.outcome == OUT_WRITTEN |->
		result.write_pixel && result.pixel_color[31:24] == ALPHA)
		else $error("written pixel malformed");

	// One request in flight: no accept in the cycle after an accept
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("request accepted while busy");

endmodule

bind point_splat_depth_test psdt_chk u_psdt_chk (.*);
